/* hdl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and command/status types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_BITS_DEF = 32;
    localparam int EXP_BITS_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

    localparam logic [DATA_W-1:0] EXPONENT_RST = 32'd17;
    localparam logic [DATA_W-1:0] MODULUS_RST  = 32'd3233;

    typedef struct packed {
        logic load;        // capture base and modulus, start reduction
        logic red_step;    // one restoring-division step of base mod m
        logic mul_start;   // clear accumulator, load multiplier operand
        logic mul_step;    // one shift-and-add step
        logic mul_sel_sq;  // 1: square base, 0: result times base
        logic mul_done;    // write product back
        logic zero_out;    // force result to zero
    } mexp_cmd_t;

    typedef struct packed {
        logic small_mod;   // modulus is 0 or 1
        logic exp_bit;     // current exponent bit
    } mexp_sts_t;

endpackage

/* hdl/mexp_datapath.sv */
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, restoring reduction and a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic                clk,
    input  logic [DATA_W-1:0]   base_in,
    input  logic [DATA_W-1:0]   modulus_in,
    input  logic [DATA_W-1:0]   exponent_in,
    input  logic [$clog2(DATA_W)-1:0]   red_idx,
    input  logic [$clog2(MOD_BITS)-1:0] mul_idx,
    input  logic [$clog2(EXP_BITS+1)-1:0] exp_idx,
    input  mexp_cmd_t           cmd,
    output mexp_sts_t           sts,
    output logic [DATA_W-1:0]   result
);

    localparam int W = MOD_BITS + 1;

    logic [MOD_BITS-1:0] m_reg, b_reg, r_reg, acc_reg, opb_reg, opa_reg;
    logic [EXP_BITS-1:0] e_reg;
    logic [EXP_BITS-1:0] e_shift;
    logic [DATA_W-1:0]   base_reg;
    logic [W-1:0]        rem_shift, rem_sub;
    logic [W-1:0]        dbl, dbl_red, add_s, add_red;
    logic [MOD_BITS-1:0] din_m;

    assign din_m = MOD_BITS'(modulus_in);

    // Restoring division step: shift in one base bit, subtract m if possible.
    assign rem_shift = {b_reg, base_reg[red_idx]};
    assign rem_sub   = rem_shift - {1'b0, m_reg};

    // Shift-and-add: acc = 2*acc mod m, then + a if bit set.
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
    assign add_s   = dbl_red + {1'b0, opa_reg};
    assign add_red = (add_s >= {1'b0, m_reg}) ? add_s - {1'b0, m_reg} : add_s;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_in;
            m_reg <= din_m;
            e_reg <= EXP_BITS'(exponent_in);
            b_reg <= '0;
            r_reg <= MOD_BITS'(1);
        end
        else if (cmd.red_step)
        begin
            if (!rem_sub[W-1])
                b_reg <= rem_sub[MOD_BITS-1:0];
            else
                b_reg <= rem_shift[MOD_BITS-1:0];
        end
        else if (cmd.mul_done)
        begin
            if (cmd.mul_sel_sq)
                b_reg <= acc_reg;
            else
                r_reg <= acc_reg;
        end
        else if (cmd.zero_out)
        begin
            r_reg <= '0;
        end

        if (cmd.mul_start)
        begin
            acc_reg <= '0;
            opa_reg <= cmd.mul_sel_sq ? b_reg : r_reg;
            opb_reg <= b_reg;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= opb_reg[mul_idx] ? add_red[MOD_BITS-1:0] : dbl_red[MOD_BITS-1:0];
        end
    end

    assign e_shift       = e_reg >> exp_idx;
    assign sts.small_mod = (din_m <= MOD_BITS'(1));
    assign sts.exp_bit   = e_shift[0];
    assign result        = DATA_W'(r_reg);

endmodule

/* hdl/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for reduction, per-bit multiply and square, and output handshake.
// ----------------------------------------------------------------------------
module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  mexp_sts_t           sts,
    output mexp_cmd_t           cmd,
    output logic [$clog2(DATA_W)-1:0]   red_idx,
    output logic [$clog2(MOD_BITS)-1:0] mul_idx,
    output logic [$clog2(EXP_BITS+1)-1:0] exp_idx
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RED   = 3'd1;
    localparam logic [2:0] ST_MSTRT = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_MDONE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam int RW = $clog2(DATA_W);
    localparam int MW = $clog2(MOD_BITS);
    localparam int XW = $clog2(EXP_BITS+1);

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] red_reg, red_next;
    logic [MW-1:0] mul_reg, mul_next;
    logic [XW-1:0] exp_reg, exp_next;
    logic          sq_reg, sq_next;
    logic          accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && !in_stall;
    assign red_idx   = red_reg;
    assign mul_idx   = mul_reg;
    assign exp_idx   = exp_reg;

    always_comb
    begin
        state_next = state_reg;
        red_next   = red_reg;
        mul_next   = mul_reg;
        exp_next   = exp_reg;
        sq_next    = sq_reg;
        cmd        = '0;
        cmd.mul_sel_sq = sq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    red_next = RW'(DATA_W - 1);
                    exp_next = '0;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (sts.small_mod)
                begin
                    cmd.zero_out = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                    red_next = red_reg - 1'b1;
                    if (red_reg == '0)
                    begin
                        sq_next = 1'b0;
                        state_next = ST_MSTRT;
                    end
                end
            end
            ST_MSTRT:
            begin
                if (exp_reg == XW'(EXP_BITS))
                    state_next = ST_OUT;
                else if (!sq_reg && !sts.exp_bit)
                    sq_next = 1'b1;
                else
                begin
                    cmd.mul_start = 1'b1;
                    mul_next = MW'(MOD_BITS - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                mul_next = mul_reg - 1'b1;
                if (mul_reg == '0)
                    state_next = ST_MDONE;
            end
            ST_MDONE:
            begin
                cmd.mul_done = 1'b1;
                if (sq_reg)
                begin
                    exp_next = exp_reg + 1'b1;
                    sq_next = 1'b0;
                end
                else
                    sq_next = 1'b1;
                state_next = ST_MSTRT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            red_reg   <= '0;
            mul_reg   <= '0;
            exp_reg   <= '0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            red_reg   <= red_next;
            mul_reg   <= mul_next;
            exp_reg   <= exp_next;
            sq_reg    <= sq_next;
        end
    end

    a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.red_step, cmd.mul_step, cmd.mul_done, cmd.zero_out}))
        else $error("conflicting datapath commands");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_RED)
        else $error("accepted request not started");
    a_mul_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> state_reg == ST_MUL)
        else $error("multiply did not start");

endmodule

/* hdl/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation of one base per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall   base_value
// output    out        out_valid/out_stall power_result
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request reduces the base mod the modulus, then for each exponent bit multiplies the
// result by the base when the bit is set and squares the base, each on the bit-serial
// multiplier; the controller returns to idle once the result is taken.
// A modulus of 0 or 1 skips the reduction and the multiplies and gives a zero result.
// Reset clears the controller and loads exponent 17 and modulus 3233.
// A waiting result holds under out_stall; no new request is taken until it leaves.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DATA_W-1:0]    base_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_W-1:0]    power_result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic [DATA_W-1:0] exponent_reg, modulus_reg;
    mexp_cmd_t cmd;
    mexp_sts_t sts;
    logic [$clog2(DATA_W)-1:0]     red_idx;
    logic [$clog2(MOD_BITS)-1:0]   mul_idx;
    logic [$clog2(EXP_BITS+1)-1:0] exp_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RST;
            modulus_reg  <= MODULUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default:      exponent_reg <= exponent_reg;
            endcase
        end
    end

    mexp_ctrl #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .sts(sts), .cmd(cmd),
        .red_idx(red_idx), .mul_idx(mul_idx), .exp_idx(exp_idx)
    );

    mexp_datapath #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_dp (
        .clk(clk),
        .base_in(base_value), .modulus_in(modulus_reg), .exponent_in(exponent_reg),
        .red_idx(red_idx), .mul_idx(mul_idx), .exp_idx(exp_idx),
        .cmd(cmd), .sts(sts), .result(power_result)
    );

endmodule
